@@ src/trhfp_pkg.sv @@
// ----------------------------------------------------------------------------
// trhfp_pkg
// Types, constants and helper functions of the text record / hex frame parser.
// ----------------------------------------------------------------------------
package trhfp_pkg;

  localparam logic [7:0] LABEL_MAX = 8'd63;
  localparam logic [7:0] VALUE_MAX = 8'd63;
  localparam logic [7:0] HEX_MAX   = 8'd255;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [7:0] END_LABEL_LEN = 8'd8;
  localparam logic [3:0] CMD_LONG      = 4'h7;
  localparam logic [7:0] CMD_LONG_MIN  = 8'd6;
  localparam logic [7:0] HEX_MIN       = 8'd3;
  localparam logic [7:0] SUM_TARGET_RST = 8'h55;

  typedef enum logic [2:0] {
    MODE_WAIT_CR = 3'd0,
    MODE_WAIT_LF = 3'd1,
    MODE_LABEL   = 3'd2,
    MODE_VALUE   = 3'd3,
    MODE_CHECK   = 3'd4,
    MODE_HEX     = 3'd5
  } mode_e;

  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_LABEL_CHAR  = 4'd1,
    EV_LABEL_DONE  = 4'd2,
    EV_VALUE_CHAR  = 4'd3,
    EV_VALUE_DONE  = 4'd4,
    EV_RECORD_GOOD = 4'd5,
    EV_HEX_BYTE    = 4'd6,
    EV_HEX_GOOD    = 4'd7,
    EV_ERROR       = 4'd8
  } event_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] position;
    logic [7:0] text_sum;
    logic [7:0] hex_sum;
    logic [3:0] high_nibble;
    logic       label_matches;
    logic       hex_bad_digit;
    logic [3:0] command_nibble;
  } parse_state_t;

  // "Checksum", one character per index
  function automatic logic [7:0] end_label_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h43;
      3'd1:    ch = 8'h68;
      3'd2:    ch = 8'h65;
      3'd3:    ch = 8'h63;
      3'd4:    ch = 8'h6B;
      3'd5:    ch = 8'h73;
      3'd6:    ch = 8'h75;
      default: ch = 8'h6D;
    endcase
    return ch;
  endfunction

  function automatic logic is_printable(input logic [7:0] c);
    return (c >= 8'h20) && (c <= 8'h7E);
  endfunction

  // bit 4 set marks a byte that is no upper-case hex digit
  function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, c[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

@@ src/trhfp_step.sv @@
// ----------------------------------------------------------------------------
// trhfp_step
// Next-state and event logic of the parser for one received byte.
// ----------------------------------------------------------------------------
module trhfp_step import trhfp_pkg::*; (
  input  parse_state_t state_i,
  input  logic [7:0]   byte_i,
  input  logic [7:0]   sum_target_i,
  output parse_state_t state_o,
  output event_e       event_o
);

  logic [7:0] sum_new;
  logic [4:0] digit;
  logic [3:0] nibble;

  assign sum_new = state_i.text_sum + byte_i;
  assign digit   = hex_digit_value(byte_i);
  assign nibble  = digit[4] ? 4'h0 : digit[3:0];

  always_comb begin
    state_o          = state_i;
    state_o.text_sum = sum_new;
    event_o          = EV_NONE;
    unique case (state_i.mode)
      MODE_WAIT_CR: begin
        if (byte_i == CHAR_CR) begin
          state_o.mode = MODE_WAIT_LF;
        end else if (byte_i == CHAR_COLON) begin
          state_o.mode           = MODE_HEX;
          state_o.position       = 8'd0;
          state_o.hex_sum        = 8'd0;
          state_o.high_nibble    = 4'd0;
          state_o.hex_bad_digit  = 1'b0;
          state_o.command_nibble = 4'd0;
        end else begin
          state_o.mode     = MODE_WAIT_CR;
          state_o.text_sum = 8'd0;
          event_o          = EV_ERROR;
        end
      end
      MODE_HEX: begin
        if (byte_i == CHAR_LF) begin
          state_o.mode     = MODE_WAIT_CR;
          state_o.text_sum = 8'd0;
          if (state_i.position < HEX_MIN || !state_i.position[0] ||
              state_i.hex_bad_digit || state_i.hex_sum != sum_target_i ||
              (state_i.command_nibble == CMD_LONG &&
               state_i.position < CMD_LONG_MIN)) begin
            event_o = EV_ERROR;
          end else begin
            event_o = EV_HEX_GOOD;
          end
        end else if (state_i.position >= HEX_MAX) begin
          state_o.mode     = MODE_WAIT_CR;
          state_o.text_sum = 8'd0;
          event_o          = EV_ERROR;
        end else begin
          if (digit[4]) begin
            state_o.hex_bad_digit = 1'b1;
          end
          if (state_i.position == 8'd0) begin
            state_o.command_nibble = nibble;
            state_o.hex_sum        = state_i.hex_sum + {4'h0, nibble};
          end else if (state_i.position[0]) begin
            state_o.high_nibble = nibble;
          end else begin
            state_o.hex_sum = state_i.hex_sum + {state_i.high_nibble, nibble};
            event_o         = EV_HEX_BYTE;
          end
          state_o.position = state_i.position + 8'd1;
        end
      end
      MODE_WAIT_LF: begin
        if (byte_i == CHAR_LF) begin
          state_o.mode          = MODE_LABEL;
          state_o.position      = 8'd0;
          state_o.label_matches = 1'b1;
        end else begin
          state_o.mode     = MODE_WAIT_CR;
          state_o.text_sum = 8'd0;
          event_o          = EV_ERROR;
        end
      end
      MODE_LABEL: begin
        if (byte_i == CHAR_TAB) begin
          if (state_i.position == 8'd0) begin
            state_o.mode     = MODE_WAIT_CR;
            state_o.text_sum = 8'd0;
            event_o          = EV_ERROR;
          end else begin
            state_o.mode = (state_i.label_matches && state_i.position == END_LABEL_LEN)
                           ? MODE_CHECK : MODE_VALUE;
            state_o.position = 8'd0;
            event_o          = EV_LABEL_DONE;
          end
        end else if (is_printable(byte_i) && state_i.position < LABEL_MAX) begin
          if (state_i.position >= END_LABEL_LEN ||
              end_label_char(state_i.position[2:0]) != byte_i) begin
            state_o.label_matches = 1'b0;
          end
          state_o.position = state_i.position + 8'd1;
          event_o          = EV_LABEL_CHAR;
        end else begin
          state_o.mode     = MODE_WAIT_CR;
          state_o.text_sum = 8'd0;
          event_o          = EV_ERROR;
        end
      end
      MODE_CHECK: begin
        state_o.mode = MODE_WAIT_CR;
        if (sum_new == 8'd0) begin
          event_o = EV_RECORD_GOOD;
        end else begin
          state_o.text_sum = 8'd0;
          event_o          = EV_ERROR;
        end
      end
      MODE_VALUE: begin
        if (byte_i == CHAR_CR) begin
          state_o.mode = MODE_WAIT_LF;
          if (state_i.position == 8'd0) begin
            state_o.text_sum = 8'd0;
            event_o          = EV_ERROR;
          end else begin
            event_o = EV_VALUE_DONE;
          end
        end else if (is_printable(byte_i) && state_i.position < VALUE_MAX) begin
          state_o.position = state_i.position + 8'd1;
          event_o          = EV_VALUE_CHAR;
        end else begin
          state_o.mode     = MODE_WAIT_CR;
          state_o.text_sum = 8'd0;
          event_o          = EV_ERROR;
        end
      end
      default: begin
        state_o.mode = MODE_WAIT_CR;
      end
    endcase
  end

endmodule

@@ src/text_record_and_hex_frame_parser.sv @@
// ----------------------------------------------------------------------------
// text_record_and_hex_frame_parser
// Parses label/tab/value text records and ':' hex frames, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
// - s_axis carries one received byte per word in tdata[7:0].
// - m_axis returns exactly one event code per input byte in tdata[3:0]
//   (upper bits zero), in input order.
// - cfg_* writes the 8-bit hex frame sum target; cfg_ready_o is always high.
//   Write it only while the parser is idle.
// - A byte is registered on acceptance and then processed, landing in the
//   output register that drives m_axis_tvalid and m_axis_tdata.
// - Throughput is one byte per cycle while the receiver does not stall;
//   the state update between the input and output registers is combinational.
// - When the receiver stalls, the output word holds and the input register
//   keeps one more byte; s_axis_tready drops only while both are full.
// - Reset clears both registers, puts the parser in the wait-for-CR state
//   and sets the sum target to 0x55.
module text_record_and_hex_frame_parser import trhfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] event_res, [7:4] zero
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  event_e       out_event_q;
  logic [7:0]   sum_target_q;
  parse_state_t state_q;
  parse_state_t state_d;
  event_e       event_d;
  logic         advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'h0, out_event_q};

  trhfp_step u_step (
    .state_i      (state_q),
    .byte_i       (in_byte_q),
    .sum_target_i (sum_target_q),
    .state_o      (state_d),
    .event_o      (event_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_event_q <= event_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: MODE_WAIT_CR, position: 8'd0, text_sum: 8'd0,
                   hex_sum: 8'd0, high_nibble: 4'd0, label_matches: 1'b1,
                   hex_bad_digit: 1'b0, command_nibble: 4'd0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_target_q <= SUM_TARGET_RST;
    end else if (cfg_valid_i) begin
      sum_target_q <= cfg_data_i;
    end
  end

endmodule

@@ src/trhfp_checker.sv @@
// ----------------------------------------------------------------------------
// trhfp_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module trhfp_checker import trhfp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // a stalled result word keeps its valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its data
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // only known event codes, padding bits zero
  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:4] == 4'h0 &&
                      m_axis_tdata[3:0] <= EV_ERROR)
    else $error("bad event code");

  // input back-pressure only comes from a stalled output
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  // an empty output never holds off the input
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind text_record_and_hex_frame_parser trhfp_checker u_trhfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
